### design/ilm_pkg.sv
// Package for the x86-64 instruction length measurer.
// Holds phase and status codes, the opcode map tables and the result type.
package ilm_pkg;

  localparam int MaxInsnsDefault = 16;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PREFIX = 3'd1,
    PH_OPCODE = 3'd2,
    PH_ESC    = 3'd3,
    PH_MODRM  = 3'd4,
    PH_SIB    = 3'd5,
    PH_TAIL   = 3'd6
  } phase_t;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_BAD_OP    = 4'd1;
  localparam logic [3:0] ST_UNSUP     = 4'd2;
  localparam logic [3:0] ST_TRUNC     = 4'd3;
  localparam logic [3:0] ST_RIP_REL   = 4'd4;
  localparam logic [3:0] ST_REL_BR    = 4'd5;
  localparam logic [3:0] ST_PREFIX67  = 4'd6;
  localparam logic [3:0] ST_PREFIX66  = 4'd7;
  localparam logic [3:0] ST_TOO_MANY  = 4'd8;

  // immediate kinds
  localparam logic [3:0] IK_NONE  = 4'd0;
  localparam logic [3:0] IK_I8    = 4'd1;
  localparam logic [3:0] IK_I16   = 4'd2;
  localparam logic [3:0] IK_I32   = 4'd3;
  localparam logic [3:0] IK_I64   = 4'd4;
  localparam logic [3:0] IK_MOFFS = 4'd5;
  localparam logic [3:0] IK_ENTER = 4'd6;
  localparam logic [3:0] IK_IW    = 4'd7;
  localparam logic [3:0] IK_G3I8  = 4'd8;
  localparam logic [3:0] IK_G3I32 = 4'd9;
  localparam logic [3:0] IK_REL8  = 4'd10;
  localparam logic [3:0] IK_REL32 = 4'd11;
  localparam logic [3:0] IK_INVAL = 4'd12;
  localparam logic [3:0] IK_UNSUP = 4'd13;

  localparam logic [7:0] MAP_ONE [256] = '{
    8'h80,8'h80,8'h80,8'h80,8'h01,8'h03,8'h0C,8'h0C,8'h80,8'h80,8'h80,8'h80,8'h01,8'h03,8'h0C,8'h0D,
    8'h80,8'h80,8'h80,8'h80,8'h01,8'h03,8'h0C,8'h0C,8'h80,8'h80,8'h80,8'h80,8'h01,8'h03,8'h0D,8'h0C,
    8'h80,8'h80,8'h80,8'h80,8'h01,8'h03,8'h0D,8'h0C,8'h80,8'h80,8'h80,8'h80,8'h01,8'h03,8'h0D,8'h0C,
    8'h80,8'h80,8'h80,8'h80,8'h01,8'h03,8'h0D,8'h0C,8'h80,8'h80,8'h80,8'h80,8'h01,8'h03,8'h0D,8'h0C,
    8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h0C,8'h0C,8'h0D,8'h80,8'h0D,8'h0D,8'h0D,8'h0D,8'h03,8'h83,8'h01,8'h81,8'h0C,8'h0C,8'h0C,8'h0C,
    8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h81,8'h83,8'h0C,8'h81,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h05,8'h05,8'h05,8'h05,8'h00,8'h00,8'h00,8'h00,8'h01,8'h03,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,
    8'h81,8'h81,8'h02,8'h00,8'h0D,8'h0D,8'h81,8'h83,8'h06,8'h00,8'h02,8'h00,8'h00,8'h01,8'h0C,8'h00,
    8'h80,8'h80,8'h80,8'h80,8'h0C,8'h0C,8'h0C,8'h00,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,
    8'h0A,8'h0A,8'h0A,8'h0A,8'h01,8'h01,8'h01,8'h01,8'h0B,8'h0B,8'h0C,8'h0A,8'h00,8'h00,8'h00,8'h00,
    8'h0D,8'h00,8'h0D,8'h0D,8'h00,8'h00,8'h88,8'h89,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h80,8'h80
  };

  // 0F map entry
  function automatic logic [7:0] map_two(input logic [7:0] b);
    logic [7:0] e;
    e = 8'h0D;
    if ((b >= 8'h10 && b <= 8'h1F) || (b >= 8'h28 && b <= 8'h2F) ||
        (b >= 8'h40 && b <= 8'h6F) || (b >= 8'h74 && b <= 8'h76) ||
        (b >= 8'h78 && b <= 8'h79) || (b >= 8'h7C && b <= 8'h7F) ||
        (b >= 8'h90 && b <= 8'h9F) || b == 8'hA3 || b == 8'hA5 ||
        (b >= 8'hAB && b <= 8'hAF) || (b >= 8'hB0 && b <= 8'hB9) ||
        (b >= 8'hBB && b <= 8'hC1) || b == 8'hC3 || b == 8'hC7 || b >= 8'hD0)
      e = 8'h80;
    if ((b >= 8'h70 && b <= 8'h73) || b == 8'hA4 || b == 8'hAC || b == 8'hBA ||
        b == 8'hC2 || (b >= 8'hC4 && b <= 8'hC6))
      e = 8'h81;
    if (b == 8'h38 || b == 8'h3A) e = 8'h0D;
    if (b >= 8'h80 && b <= 8'h8F) e = 8'h0B;
    if ((b >= 8'h05 && b <= 8'h09) || b == 8'h0B || (b >= 8'h30 && b <= 8'h35) ||
        b == 8'h37 || b == 8'h77 || (b >= 8'hA0 && b <= 8'hA2) ||
        (b >= 8'hA8 && b <= 8'hAA) || (b >= 8'hC8 && b <= 8'hCF))
      e = 8'h00;
    return e;
  endfunction

  // immediate byte count for a kind
  function automatic logic [3:0] imm_bytes(input logic [3:0] kind, input logic [7:0] modrm,
                                           input logic wide);
    logic low_reg;
    logic [3:0] n;
    low_reg = (modrm[5:3] <= 3'd1);
    case (kind)
      IK_I8:    n = 4'd1;
      IK_I16:   n = 4'd2;
      IK_I32:   n = 4'd4;
      IK_I64:   n = 4'd8;
      IK_MOFFS: n = 4'd8;
      IK_ENTER: n = 4'd3;
      IK_IW:    n = wide ? 4'd8 : 4'd4;
      IK_G3I8:  n = low_reg ? 4'd1 : 4'd0;
      IK_G3I32: n = low_reg ? 4'd4 : 4'd0;
      default:  n = 4'd0;
    endcase
    return n;
  endfunction

  typedef struct packed {
    logic [7:0] insn_length;
    logic [3:0] status;
    logic       modrm_used;
    logic [8:0] insn_offset;
    logic [8:0] total_length;
    logic [4:0] insn_count;
    logic       done_res;
  } result_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       start_req;
    logic       end_of_buffer;
  } item_t;

endpackage

### design/ilm_if.sv
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; payload type is a parameter.
interface ilm_if #(parameter type payload_t = logic [7:0]) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/ilm_outq.sv
// Four-entry result queue that parts the decoder from the output channel.
// Depends on ilm_pkg.
module ilm_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push0,
  input  logic             push1,
  input  ilm_pkg::result_t wr0,
  input  ilm_pkg::result_t wr1,
  output logic             room,
  output logic             valid,
  input  logic             pop,
  output ilm_pkg::result_t rd
);
  import ilm_pkg::*;

  result_t    slot [4];
  logic [1:0] head;
  logic [1:0] tail;
  logic [2:0] count;
  logic [2:0] count_next;
  logic [2:0] npush;

  assign npush = {2'b0, push0} + {2'b0, push1};
  assign valid = (count != 3'd0);
  assign rd = slot[head];
  // accept only when two free slots remain, so any item can land
  assign room = (count <= 3'd2);
  assign count_next = count + npush - {2'b0, pop & valid};

  // advance pointers and store results
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 2'd0;
      tail  <= 2'd0;
      count <= 3'd0;
    end else begin
      if (push0) slot[tail] <= wr0;
      if (push1) slot[tail + 2'd1] <= wr1;
      tail  <= tail + npush[1:0];
      if (pop && valid) head <= head + 2'd1;
      count <= count_next;
    end
  end
endmodule

### design/x86_64_insn_length_measure_top.sv
// Top level of the x86-64 instruction length measurer with its APB register.
// Depends on ilm_pkg, ilm_if and ilm_outq.
//
// One code byte is taken per cycle while the queue has room; each byte steps the decode state and a
// finished instruction emits one or two result items into a four-entry queue.
// A result item enters the queue at the edge that accepts its byte and is offered once older items have gone.
// Input ready drops only when the queue holds more than two items, so the
// block takes one byte per clock as long as the sink drains results as fast
// as they are made; bytes that each end a measurement with two results
// outrun a one-per-clock sink and stall the input.
module x86_64_insn_length_measure_top #(
  parameter int MAX_INSNS = ilm_pkg::MaxInsnsDefault
) (
  input  logic        clk,
  input  logic        rst,
  ilm_if.sink         in_ch,
  ilm_if.source       out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ilm_pkg::*;

  logic [7:0] need_bytes;
  phase_t     phase, phase_next;
  logic       saw_size_prefix, saw_size_prefix_next;
  logic       saw_addr_prefix, saw_addr_prefix_next;
  logic       rex_wide, rex_wide_next;
  logic       wants_modrm, wants_modrm_next;
  logic [3:0] imm_kind, imm_kind_next;
  logic [7:0] modrm_value, modrm_value_next;
  logic [3:0] bytes_pending, bytes_pending_next;
  logic [7:0] cur_length, cur_length_next;
  logic [8:0] covered_bytes, covered_bytes_next;
  logic [4:0] decoded_count, decoded_count_next;

  item_t      it;
  logic       take;
  logic       room;
  logic       push0, push1;
  result_t    wr0, wr1;

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {24'd0, need_bytes} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      need_bytes <= 8'd5;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      need_bytes <= pwdata[7:0];
    end
  end

  assign it = in_ch.data;
  assign in_ch.ready = room;
  assign take = in_ch.valid && room;

  // decode one byte
  always_comb begin
    phase_t     ph;
    logic [7:0] len;
    logic [7:0] ent;
    logic       use_ent;
    logic       more;
    logic       fail;
    logic [3:0] fst;
    logic [3:0] pend;
    logic       setp;
    logic [3:0] disp;
    logic [9:0] sum;
    logic [4:0] cnt;
    logic [7:0] need;
    logic [7:0] b;
    b = it.code_byte;
    ph = phase;
    saw_size_prefix_next = saw_size_prefix;
    saw_addr_prefix_next = saw_addr_prefix;
    rex_wide_next = rex_wide;
    wants_modrm_next = wants_modrm;
    imm_kind_next = imm_kind;
    modrm_value_next = modrm_value;
    bytes_pending_next = bytes_pending;
    len = cur_length;
    covered_bytes_next = covered_bytes;
    decoded_count_next = decoded_count;
    push0 = 1'b0;
    push1 = 1'b0;
    wr0 = '0;
    wr1 = '0;
    more = 1'b1;
    fail = 1'b0;
    fst = ST_OK;
    use_ent = 1'b0;
    ent = 8'h00;
    setp = 1'b0;
    pend = 4'd0;
    disp = 4'd0;
    sum = 10'd0;
    cnt = 5'd0;
    need = 8'd1;
    phase_next = phase;
    cur_length_next = cur_length;
    if (take) begin
      if (it.start_req) begin
        saw_size_prefix_next = 1'b0;
        saw_addr_prefix_next = 1'b0;
        rex_wide_next = 1'b0;
        wants_modrm_next = 1'b0;
        imm_kind_next = IK_NONE;
        modrm_value_next = 8'd0;
        bytes_pending_next = 4'd0;
        len = 8'd0;
        covered_bytes_next = 9'd0;
        decoded_count_next = 5'd0;
        ph = PH_PREFIX;
      end
      phase_next = ph;
      if (ph != PH_IDLE) begin
        if (len != 8'd255) len = len + 8'd1;
        case (ph)
          PH_PREFIX: begin
            if (b == 8'h66) saw_size_prefix_next = 1'b1;
            else if (b == 8'h67) saw_addr_prefix_next = 1'b1;
            else if (b == 8'hF0 || b == 8'hF2 || b == 8'hF3 || b == 8'h2E ||
                     b == 8'h36 || b == 8'h3E || b == 8'h26 || b == 8'h64 ||
                     b == 8'h65) begin
              more = 1'b1;
            end else if (saw_addr_prefix_next) begin
              fail = 1'b1; fst = ST_PREFIX67;
            end else if (saw_size_prefix_next) begin
              fail = 1'b1; fst = ST_PREFIX66;
            end else if (b >= 8'h40 && b <= 8'h4F) begin
              rex_wide_next = b[3];
              phase_next = PH_OPCODE;
            end else if (b == 8'h0F) begin
              phase_next = PH_ESC;
            end else begin
              use_ent = 1'b1; ent = MAP_ONE[b];
            end
          end
          PH_OPCODE: begin
            if (b == 8'h0F) phase_next = PH_ESC;
            else begin
              use_ent = 1'b1; ent = MAP_ONE[b];
            end
          end
          PH_ESC: begin
            use_ent = 1'b1; ent = map_two(b);
          end
          PH_MODRM: begin
            modrm_value_next = b;
            if (b[7:6] == 2'd3) begin
              setp = 1'b1; pend = imm_bytes(imm_kind, b, rex_wide);
            end else if (b[2:0] == 3'd4) begin
              phase_next = PH_SIB;
            end else if (b[7:6] == 2'd0 && b[2:0] == 3'd5) begin
              fail = 1'b1; fst = ST_RIP_REL;
            end else begin
              disp = (b[7:6] == 2'd1) ? 4'd1 : ((b[7:6] == 2'd2) ? 4'd4 : 4'd0);
              setp = 1'b1; pend = disp + imm_bytes(imm_kind, b, rex_wide);
            end
          end
          PH_SIB: begin
            if (modrm_value[7:6] == 2'd0) disp = (b[2:0] == 3'd5) ? 4'd4 : 4'd0;
            else disp = (modrm_value[7:6] == 2'd1) ? 4'd1 : 4'd4;
            setp = 1'b1; pend = disp + imm_bytes(imm_kind, modrm_value, rex_wide);
          end
          default: begin
            if (bytes_pending <= 4'd1) begin
              bytes_pending_next = 4'd0;
              more = 1'b0;
            end else begin
              bytes_pending_next = bytes_pending - 4'd1;
            end
          end
        endcase
        if (use_ent) begin
          if (ent[3:0] == IK_INVAL) begin
            fail = 1'b1; fst = ST_BAD_OP;
          end else if (ent[3:0] == IK_UNSUP) begin
            fail = 1'b1; fst = ST_UNSUP;
          end else if (ent[3:0] == IK_REL8 || ent[3:0] == IK_REL32) begin
            fail = 1'b1; fst = ST_REL_BR;
          end else begin
            imm_kind_next = ent[3:0];
            if (ent[7]) begin
              wants_modrm_next = 1'b1;
              phase_next = PH_MODRM;
            end else begin
              setp = 1'b1; pend = imm_bytes(ent[3:0], 8'd0, rex_wide);
            end
          end
        end
        if (setp) begin
          bytes_pending_next = pend;
          if (pend == 4'd0) more = 1'b0;
          else phase_next = PH_TAIL;
        end
        if (more && !fail && it.end_of_buffer) begin
          fail = 1'b1; fst = ST_TRUNC;
        end
        if (fail) begin
          push0 = 1'b1;
          wr0 = '{insn_length: 8'd0, status: fst, modrm_used: 1'b0,
                  insn_offset: covered_bytes_next, total_length: covered_bytes_next,
                  insn_count: decoded_count_next, done_res: 1'b1};
          phase_next = PH_IDLE;
        end else if (!more) begin
          sum = {1'b0, covered_bytes_next} + {2'b0, len};
          cnt = (decoded_count_next != 5'd31) ? decoded_count_next + 5'd1
                                               : decoded_count_next;
          need = (need_bytes == 8'd0) ? 8'd1 : need_bytes;
          push0 = 1'b1;
          wr0 = '{insn_length: len, status: ST_OK, modrm_used: wants_modrm_next,
                  insn_offset: covered_bytes_next,
                  total_length: sum[9] ? 9'd511 : sum[8:0],
                  insn_count: cnt, done_res: 1'b0};
          wr1 = wr0;
          wr1.insn_length = 8'd0;
          wr1.modrm_used = 1'b0;
          wr1.done_res = 1'b1;
          phase_next = PH_PREFIX;
          if ({27'd0, cnt} > MAX_INSNS) begin
            push1 = 1'b1; wr1.status = ST_TOO_MANY;
            phase_next = PH_IDLE;
          end else if (wr0.total_length >= {1'b0, need}) begin
            wr0.done_res = 1'b1;
            phase_next = PH_IDLE;
          end else if (it.end_of_buffer) begin
            push1 = 1'b1; wr1.status = ST_TRUNC;
            wr1.insn_offset = wr0.total_length;
            phase_next = PH_IDLE;
          end
          covered_bytes_next = wr0.total_length;
          decoded_count_next = cnt;
        end
        if (fail || !more) begin
          saw_size_prefix_next = 1'b0;
          saw_addr_prefix_next = 1'b0;
          rex_wide_next = 1'b0;
          wants_modrm_next = 1'b0;
          imm_kind_next = IK_NONE;
          modrm_value_next = 8'd0;
          bytes_pending_next = 4'd0;
          len = 8'd0;
        end
      end
      cur_length_next = len;
    end
  end

  // hold decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      saw_size_prefix <= 1'b0;
      saw_addr_prefix <= 1'b0;
      rex_wide <= 1'b0;
      wants_modrm <= 1'b0;
      imm_kind <= IK_NONE;
      modrm_value <= 8'd0;
      bytes_pending <= 4'd0;
      cur_length <= 8'd0;
      covered_bytes <= 9'd0;
      decoded_count <= 5'd0;
    end else begin
      phase <= phase_next;
      saw_size_prefix <= saw_size_prefix_next;
      saw_addr_prefix <= saw_addr_prefix_next;
      rex_wide <= rex_wide_next;
      wants_modrm <= wants_modrm_next;
      imm_kind <= imm_kind_next;
      modrm_value <= modrm_value_next;
      bytes_pending <= bytes_pending_next;
      cur_length <= cur_length_next;
      covered_bytes <= covered_bytes_next;
      decoded_count <= decoded_count_next;
    end
  end

  ilm_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push0 (push0),
    .push1 (push1),
    .wr0   (wr0),
    .wr1   (wr1),
    .room  (room),
    .valid (out_ch.valid),
    .pop   (out_ch.ready),
    .rd    (out_ch.data)
  );
endmodule

### tb/tb.sv
// Self-checking bench for the x86-64 instruction length measurer.
// Depends on ilm_pkg, ilm_if and x86_64_insn_length_measure_top; decodes the
// byte stream in parallel and checks every result item in order.
module tb;
  import ilm_pkg::*;

  localparam int MoreBytes = -1;
  localparam int InsnDone  = -2;
  localparam int CycleLimit = 400000;

  // one-byte opcode map: bit 7 ModRM follows, low nibble immediate kind
  localparam logic [7:0] OneByteMap [256] = '{
    8'h80,8'h80,8'h80,8'h80,8'h01,8'h03,8'h0C,8'h0C,8'h80,8'h80,8'h80,8'h80,8'h01,8'h03,8'h0C,8'h0D,
    8'h80,8'h80,8'h80,8'h80,8'h01,8'h03,8'h0C,8'h0C,8'h80,8'h80,8'h80,8'h80,8'h01,8'h03,8'h0D,8'h0C,
    8'h80,8'h80,8'h80,8'h80,8'h01,8'h03,8'h0D,8'h0C,8'h80,8'h80,8'h80,8'h80,8'h01,8'h03,8'h0D,8'h0C,
    8'h80,8'h80,8'h80,8'h80,8'h01,8'h03,8'h0D,8'h0C,8'h80,8'h80,8'h80,8'h80,8'h01,8'h03,8'h0D,8'h0C,
    8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,8'h0D,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h0C,8'h0C,8'h0D,8'h80,8'h0D,8'h0D,8'h0D,8'h0D,8'h03,8'h83,8'h01,8'h81,8'h0C,8'h0C,8'h0C,8'h0C,
    8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,8'h0A,
    8'h81,8'h83,8'h0C,8'h81,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,
    8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h05,8'h05,8'h05,8'h05,8'h00,8'h00,8'h00,8'h00,8'h01,8'h03,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
    8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,8'h07,
    8'h81,8'h81,8'h02,8'h00,8'h0D,8'h0D,8'h81,8'h83,8'h06,8'h00,8'h02,8'h00,8'h00,8'h01,8'h0C,8'h00,
    8'h80,8'h80,8'h80,8'h80,8'h0C,8'h0C,8'h0C,8'h00,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,
    8'h0A,8'h0A,8'h0A,8'h0A,8'h01,8'h01,8'h01,8'h01,8'h0B,8'h0B,8'h0C,8'h0A,8'h00,8'h00,8'h00,8'h00,
    8'h0D,8'h00,8'h0D,8'h0D,8'h00,8'h00,8'h88,8'h89,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h80,8'h80
  };

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  ilm_if #(.payload_t(item_t))   in_if (clk);
  ilm_if #(.payload_t(result_t)) out_if (clk);

  x86_64_insn_length_measure_top dut (
    .clk(clk), .rst(rst), .in_ch(in_if), .out_ch(out_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // decoder shadow state
  phase_t     ph;
  logic       sz_pfx, ad_pfx, rex_w, want_mrm;
  logic [3:0] imm_k, pend;
  logic [7:0] mrm_byte, cur_len, need_cfg;
  logic [8:0] covered;
  logic [4:0] n_done;

  result_t results_due[$];
  result_t new_results[$];
  item_t   stim[$];
  int      fails;
  bit      idle_on;
  bit      hold_out;
  int      cycles;

  always #10 clk = ~clk;

  function automatic logic [7:0] escape_map(logic [7:0] b);
    if ((b >= 8'h05 && b <= 8'h09) || b == 8'h0B || (b >= 8'h30 && b <= 8'h35) ||
        b == 8'h37 || b == 8'h77 || (b >= 8'hA0 && b <= 8'hA2) ||
        (b >= 8'hA8 && b <= 8'hAA) || (b >= 8'hC8 && b <= 8'hCF))
      return 8'h00;
    if (b >= 8'h80 && b <= 8'h8F) return 8'h0B;
    if (b == 8'h38 || b == 8'h3A) return 8'h0D;
    if ((b >= 8'h70 && b <= 8'h73) || b == 8'hA4 || b == 8'hAC || b == 8'hBA ||
        b == 8'hC2 || (b >= 8'hC4 && b <= 8'hC6))
      return 8'h81;
    if ((b >= 8'h10 && b <= 8'h1F) || (b >= 8'h28 && b <= 8'h2F) ||
        (b >= 8'h40 && b <= 8'h6F) || (b >= 8'h74 && b <= 8'h76) ||
        (b >= 8'h78 && b <= 8'h79) || (b >= 8'h7C && b <= 8'h7F) ||
        (b >= 8'h90 && b <= 8'h9F) || b == 8'hA3 || b == 8'hA5 ||
        (b >= 8'hAB && b <= 8'hAF) || (b >= 8'hB0 && b <= 8'hB9) ||
        (b >= 8'hBB && b <= 8'hC1) || b == 8'hC3 || b == 8'hC7 || b >= 8'hD0)
      return 8'h80;
    return 8'h0D;
  endfunction

  function automatic logic [3:0] imm_len(logic [3:0] k, logic [7:0] m, logic w);
    logic lo;
    lo = (m[5:3] <= 3'd1);
    case (k)
      IK_I8:    return 4'd1;
      IK_I16:   return 4'd2;
      IK_I32:   return 4'd4;
      IK_I64, IK_MOFFS: return 4'd8;
      IK_ENTER: return 4'd3;
      IK_IW:    return w ? 4'd8 : 4'd4;
      IK_G3I8:  return lo ? 4'd1 : 4'd0;
      IK_G3I32: return lo ? 4'd4 : 4'd0;
      default:  return 4'd0;
    endcase
  endfunction

  function automatic bit is_legacy(logic [7:0] b);
    return b == 8'hF0 || b == 8'hF2 || b == 8'hF3 || b == 8'h2E || b == 8'h36 ||
           b == 8'h3E || b == 8'h26 || b == 8'h64 || b == 8'h65;
  endfunction

  function automatic void clear_insn();
    sz_pfx = 0; ad_pfx = 0; rex_w = 0; want_mrm = 0;
    imm_k = 0; mrm_byte = 0; pend = 0; cur_len = 0;
  endfunction

  function automatic int arm_tail(logic [3:0] n);
    pend = n;
    if (n == 0) return InsnDone;
    ph = PH_TAIL;
    return MoreBytes;
  endfunction

  function automatic int take_entry(logic [7:0] e);
    logic [3:0] k;
    k = e[3:0];
    if (k == IK_INVAL) return int'(ST_BAD_OP);
    if (k == IK_UNSUP) return int'(ST_UNSUP);
    if (k == IK_REL8 || k == IK_REL32) return int'(ST_REL_BR);
    imm_k = k;
    if (e[7]) begin
      want_mrm = 1;
      ph = PH_MODRM;
      return MoreBytes;
    end
    return arm_tail(imm_len(k, 8'h00, rex_w));
  endfunction

  function automatic int take_opcode(logic [7:0] b);
    if (b == 8'h0F) begin
      ph = PH_ESC;
      return MoreBytes;
    end
    return take_entry(OneByteMap[b]);
  endfunction

  // advance the decode by one byte; status code, MoreBytes or InsnDone
  function automatic int decode_byte(logic [7:0] b);
    logic [1:0] md;
    logic [3:0] dsp;
    case (ph)
      PH_PREFIX: begin
        if (b == 8'h66) begin sz_pfx = 1; return MoreBytes; end
        if (b == 8'h67) begin ad_pfx = 1; return MoreBytes; end
        if (is_legacy(b)) return MoreBytes;
        if (ad_pfx) return int'(ST_PREFIX67);
        if (sz_pfx) return int'(ST_PREFIX66);
        if (b[7:4] == 4'h4) begin
          rex_w = b[3];
          ph = PH_OPCODE;
          return MoreBytes;
        end
        return take_opcode(b);
      end
      PH_OPCODE: return take_opcode(b);
      PH_ESC: return take_entry(escape_map(b));
      PH_MODRM: begin
        mrm_byte = b;
        md = b[7:6];
        if (md == 2'd3) return arm_tail(imm_len(imm_k, b, rex_w));
        if (b[2:0] == 3'd4) begin
          ph = PH_SIB;
          return MoreBytes;
        end
        if (md == 2'd0 && b[2:0] == 3'd5) return int'(ST_RIP_REL);
        dsp = (md == 2'd1) ? 4'd1 : (md == 2'd2 ? 4'd4 : 4'd0);
        return arm_tail(dsp + imm_len(imm_k, b, rex_w));
      end
      PH_SIB: begin
        md = mrm_byte[7:6];
        if (md == 2'd0) dsp = (b[2:0] == 3'd5) ? 4'd4 : 4'd0;
        else dsp = (md == 2'd1) ? 4'd1 : 4'd4;
        return arm_tail(dsp + imm_len(imm_k, mrm_byte, rex_w));
      end
      default: begin
        if (pend <= 4'd1) begin
          pend = 4'd0;
          return InsnDone;
        end
        pend = pend - 4'd1;
        return MoreBytes;
      end
    endcase
  endfunction

  function automatic result_t mk(logic [7:0] len, logic [3:0] st, logic m,
                                 logic [8:0] off, logic dn);
    result_t r;
    r.insn_length = len; r.status = st; r.modrm_used = m; r.insn_offset = off;
    r.total_length = covered; r.insn_count = n_done; r.done_res = dn;
    return r;
  endfunction

  // predict the results of one accepted byte into new_results
  function automatic void measure_byte(item_t it);
    int act;
    logic [8:0] off, needv;
    logic [9:0] sum;
    logic [7:0] len;
    logic m;
    new_results.delete();
    if (it.start_req) begin
      clear_insn();
      covered = 9'd0;
      n_done = 5'd0;
      ph = PH_PREFIX;
    end
    if (ph == PH_IDLE) return;
    if (cur_len < 8'd255) cur_len = cur_len + 8'd1;
    act = decode_byte(it.code_byte);
    if (act == MoreBytes && it.end_of_buffer) act = int'(ST_TRUNC);
    if (act == MoreBytes) return;
    off = covered;
    if (act >= 0) begin
      new_results.push_back(mk(8'd0, act[3:0], 1'b0, off, 1'b1));
      ph = PH_IDLE;
      clear_insn();
      return;
    end
    len = cur_len;
    m = want_mrm;
    sum = {1'b0, covered} + {2'b0, len};
    covered = (sum > 10'd511) ? 9'd511 : sum[8:0];
    if (n_done < 5'd31) n_done = n_done + 5'd1;
    clear_insn();
    ph = PH_PREFIX;
    needv = (need_cfg == 8'd0) ? 9'd1 : {1'b0, need_cfg};
    if (n_done > MaxInsnsDefault) begin
      new_results.push_back(mk(len, ST_OK, m, off, 1'b0));
      new_results.push_back(mk(8'd0, ST_TOO_MANY, 1'b0, off, 1'b1));
      ph = PH_IDLE;
    end else if (covered >= needv) begin
      new_results.push_back(mk(len, ST_OK, m, off, 1'b1));
      ph = PH_IDLE;
    end else if (it.end_of_buffer) begin
      new_results.push_back(mk(len, ST_OK, m, off, 1'b0));
      new_results.push_back(mk(8'd0, ST_TRUNC, 1'b0, covered, 1'b1));
      ph = PH_IDLE;
    end else begin
      new_results.push_back(mk(len, ST_OK, m, off, 1'b0));
    end
  endfunction

  // offer one item, wait for acceptance, then record what it should cause
  task automatic send_item(item_t it, bit typed, result_t want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk); while (!in_if.ready);
    measure_byte(it);
    if (typed) results_due.push_back(want);
    else foreach (new_results[i]) results_due.push_back(new_results[i]);
  endtask

  task automatic write_need(logic [7:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    need_cfg = v;
  endtask

  task automatic drain();
    wait (results_due.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic void push_byte(logic [7:0] b, bit st, bit eob);
    item_t it;
    it.code_byte = b; it.start_req = st; it.end_of_buffer = eob;
    stim.push_back(it);
  endfunction

  // append one mostly well-formed instruction
  function automatic void gen_insn();
    logic [7:0] b, b2, e, m, sib;
    logic w;
    int tail, k;
    w = 0;
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, 8);
      case (k)
        0: push_byte(8'hF0, 0, 0); 1: push_byte(8'hF2, 0, 0); 2: push_byte(8'hF3, 0, 0);
        3: push_byte(8'h2E, 0, 0); 4: push_byte(8'h36, 0, 0); 5: push_byte(8'h3E, 0, 0);
        6: push_byte(8'h26, 0, 0); 7: push_byte(8'h64, 0, 0); default: push_byte(8'h65, 0, 0);
      endcase
    end
    if ($urandom_range(0, 39) == 0) push_byte($urandom_range(0, 1) ? 8'h66 : 8'h67, 0, 0);
    if ($urandom_range(0, 3) == 0) begin
      b = 8'h40 | 8'($urandom_range(0, 15));
      w = b[3];
      push_byte(b, 0, 0);
    end
    do begin
      b = 8'($urandom_range(0, 255));
      b2 = 8'($urandom_range(0, 255));
      e = (b == 8'h0F) ? escape_map(b2) : OneByteMap[b];
    end while (is_legacy(b) || b == 8'h66 || b == 8'h67 ||
               (e[3:0] >= IK_REL8 && $urandom_range(0, 9) != 0));
    push_byte(b, 0, 0);
    if (b == 8'h0F) push_byte(b2, 0, 0);
    tail = 0;
    if (e[7]) begin
      m = 8'($urandom_range(0, 255));
      if (m[7:6] == 2'd0 && m[2:0] == 3'd5 && $urandom_range(0, 7) != 0) m[0] = 1'b0;
      push_byte(m, 0, 0);
      tail = int'(imm_len(e[3:0], m, w));
      if (m[7:6] != 2'd3) begin
        if (m[2:0] == 3'd4) begin
          sib = 8'($urandom_range(0, 255));
          push_byte(sib, 0, 0);
          tail += (m[7:6] == 2'd0) ? ((sib[2:0] == 3'd5) ? 4 : 0) : (m[7:6] == 2'd1 ? 1 : 4);
        end else begin
          tail += (m[7:6] == 2'd1) ? 1 : (m[7:6] == 2'd2 ? 4 : 0);
        end
      end
    end else begin
      tail = int'(imm_len(e[3:0], 8'h00, w));
    end
    repeat (tail) push_byte(8'($urandom_range(0, 255)), 0, 0);
  endfunction

  // one measurement: start on the first byte, end in one of several ways
  function automatic void gen_measurement(int max_insns);
    int first, cut, n;
    first = stim.size();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)), 0, 0);
    end else begin
      n = $urandom_range(1, max_insns);
      repeat (n) gen_insn();
    end
    stim[first].start_req = 1'b1;
    case ($urandom_range(0, 3))
      0: stim[stim.size() - 1].end_of_buffer = 1'b1;
      1: begin
        cut = $urandom_range(0, 3);
        while (cut > 0 && stim.size() - 1 > first) begin
          void'(stim.pop_back());
          cut--;
        end
        stim[stim.size() - 1].end_of_buffer = 1'b1;
      end
      default: ;
    endcase
    // trailing noise without a start
    repeat ($urandom_range(0, 2))
      push_byte(8'($urandom_range(0, 255)), 0, 1'($urandom_range(0, 1)));
  endfunction

  task automatic random_phase(logic [7:0] nv, int max_insns, int n_items);
    result_t none;
    none = '0;
    write_need(nv);
    stim.delete();
    while (stim.size() < n_items) gen_measurement(max_insns);
    foreach (stim[i]) send_item(stim[i], 1'b0, none);
    in_if.valid <= 1'b0;
    drain();
  endtask

  // receiver: random stalls, plus one long hold when requested
  initial begin
    @(negedge rst);
    forever begin
      if (hold_out) begin
        out_if.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_out = 0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result item %p", out_if.data);
        fails++;
      end else begin
        result_t w;
        w = results_due.pop_front();
        if (out_if.data.insn_length !== w.insn_length) begin
          $error("insn_length exp %0d got %0d", w.insn_length, out_if.data.insn_length);
          fails++;
        end
        if (out_if.data.status !== w.status) begin
          $error("status exp %0d got %0d", w.status, out_if.data.status);
          fails++;
        end
        if (out_if.data.modrm_used !== w.modrm_used) begin
          $error("modrm_used exp %0d got %0d", w.modrm_used, out_if.data.modrm_used);
          fails++;
        end
        if (out_if.data.insn_offset !== w.insn_offset) begin
          $error("insn_offset exp %0d got %0d", w.insn_offset, out_if.data.insn_offset);
          fails++;
        end
        if (out_if.data.total_length !== w.total_length) begin
          $error("total_length exp %0d got %0d", w.total_length, out_if.data.total_length);
          fails++;
        end
        if (out_if.data.insn_count !== w.insn_count) begin
          $error("insn_count exp %0d got %0d", w.insn_count, out_if.data.insn_count);
          fails++;
        end
        if (out_if.data.done_res !== w.done_res) begin
          $error("done_res exp %0d got %0d", w.done_res, out_if.data.done_res);
          fails++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t r;
    clk = 0; rst = 1; fails = 0; cycles = 0; idle_on = 1; hold_out = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_if.valid = 0; in_if.data = '0; out_if.ready = 0;
    need_cfg = 8'd5; ph = PH_IDLE; covered = 0; n_done = 0;
    clear_insn();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: byte, start, end of buffer, typed?, expected
    rows = '{
      '{'{8'h90, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h06, 1'b1, 1'b0}, 1'b1, '{8'd0, ST_BAD_OP, 1'b0, 9'd0, 9'd0, 5'd0, 1'b1}},
      '{'{8'h67, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h66, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h90, 1'b0, 1'b0}, 1'b1, '{8'd0, ST_PREFIX67, 1'b0, 9'd0, 9'd0, 5'd0, 1'b1}},
      '{'{8'h66, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h01, 1'b0, 1'b0}, 1'b1, '{8'd0, ST_PREFIX66, 1'b0, 9'd0, 9'd0, 5'd0, 1'b1}},
      '{'{8'h48, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h4F, 1'b0, 1'b0}, 1'b1, '{8'd0, ST_UNSUP, 1'b0, 9'd0, 9'd0, 5'd0, 1'b1}},
      '{'{8'h70, 1'b1, 1'b0}, 1'b1, '{8'd0, ST_REL_BR, 1'b0, 9'd0, 9'd0, 5'd0, 1'b1}},
      '{'{8'h8B, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h05, 1'b0, 1'b0}, 1'b1, '{8'd0, ST_RIP_REL, 1'b0, 9'd0, 9'd0, 5'd0, 1'b1}},
      '{'{8'hF0, 1'b1, 1'b1}, 1'b1, '{8'd0, ST_TRUNC, 1'b0, 9'd0, 9'd0, 5'd0, 1'b1}},
      '{'{8'hC3, 1'b1, 1'b1}, 1'b0, '0},
      '{'{8'h48, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'hB8, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'hFF, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h00, 1'b0, 1'b0}, 1'b0, '0},
      '{'{8'h0F, 1'b1, 1'b0}, 1'b0, '0},
      '{'{8'h80, 1'b0, 1'b0}, 1'b1, '{8'd0, ST_REL_BR, 1'b0, 9'd0, 9'd0, 5'd0, 1'b1}}
    };
    foreach (rows[i]) begin
      r = rows[i];
      send_item(r.it, r.typed, r.want);
    end
    in_if.valid <= 1'b0;
    drain();

    // random: long measurements under a receiver hold, then small and mid needs, then random needs without idle gaps
    hold_out = 1;
    random_phase(8'd255, 22, 300);
    random_phase(8'd1, 3, 250);
    random_phase(8'($urandom_range(2, 40)), 8, 250);
    idle_on = 0;
    random_phase(8'($urandom_range(1, 255)), 20, 250);

    repeat (20) @(posedge clk);
    if (fails == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
